// File: hw/rtl/mtm_pkg.sv
`default_nettype none

package mtm_pkg;

    localparam int TAPE_BITS = 4096;
    localparam int TAPE_AW   = $clog2(TAPE_BITS);

    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_STEP    = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    localparam logic [4:0] NUM_STATES = 5'd17;
    localparam logic [4:0] ST_READ    = 5'd15;
    localparam logic [4:0] ST_EMIT    = 5'd16;

    typedef struct packed {
        logic       wr_one;
        logic       mv_right;
        logic [4:0] nxt;
    } t_entry;

    // Word handed from the top level to the step unit.
    typedef struct packed {
        logic [1:0]         req_type;
        logic [11:0]        load_addr;
        logic               load_bit;
        logic               in_bit;
        logic               sym;
        logic [4:0]         state;
        logic [TAPE_AW-1:0] head;
    } t_ex_req;

    // Tape write, new machine registers and the result word.
    typedef struct packed {
        logic               wr_en;
        logic [TAPE_AW-1:0] wr_addr;
        logic               wr_bit;
        logic [4:0]         state;
        logic [TAPE_AW-1:0] head;
        logic               out_valid;
        logic               out_bit;
        logic               in_taken;
        logic               overflow;
    } t_ex_res;

    function automatic t_entry step_entry(input logic [4:0] state, input logic sym);
        t_entry e0;
        t_entry e1;
        case (state)
            5'd0:  begin e0 = '{1'b1, 1'b1, 5'd0};  e1 = '{1'b0, 1'b1, 5'd1};  end
            5'd1:  begin e0 = '{1'b1, 1'b1, 5'd0};  e1 = '{1'b1, 1'b1, 5'd2};  end
            5'd2:  begin e0 = '{1'b0, 1'b0, 5'd4};  e1 = '{1'b0, 1'b0, 5'd6};  end
            5'd3:  begin e0 = '{1'b1, 1'b0, 5'd4};  e1 = '{1'b0, 1'b0, 5'd5};  end
            5'd4:  begin e0 = '{1'b1, 1'b0, 5'd3};  e1 = '{1'b1, 1'b1, 5'd0};  end
            5'd5:  begin e0 = '{1'b1, 1'b0, 5'd3};  e1 = '{1'b1, 1'b0, 5'd3};  end
            5'd6:  begin e0 = '{1'b1, 1'b0, 5'd6};  e1 = '{1'b0, 1'b0, 5'd7};  end
            5'd7:  begin e0 = '{1'b1, 1'b0, 5'd6};  e1 = '{1'b1, 1'b0, 5'd8};  end
            5'd8:  begin e0 = '{1'b1, 1'b0, 5'd9};  e1 = '{1'b0, 1'b1, 5'd0};  end
            5'd9:  begin e0 = '{1'b0, 1'b0, 5'd15}; e1 = '{1'b0, 1'b0, 5'd10}; end
            5'd10: begin e0 = '{1'b1, 1'b1, 5'd13}; e1 = '{1'b0, 1'b1, 5'd11}; end
            5'd11: begin e0 = '{1'b1, 1'b1, 5'd11}; e1 = '{1'b0, 1'b1, 5'd12}; end
            5'd12: begin e0 = '{1'b1, 1'b1, 5'd11}; e1 = '{1'b0, 1'b0, 5'd1};  end
            5'd13: begin e0 = '{1'b0, 1'b1, 5'd14}; e1 = '{1'b0, 1'b0, 5'd2};  end
            5'd14: begin e0 = '{1'b1, 1'b1, 5'd13}; e1 = '{1'b0, 1'b1, 5'd13}; end
            5'd15: begin e0 = '{1'b0, 1'b0, 5'd0};  e1 = '{1'b1, 1'b0, 5'd16}; end
            default: begin e0 = '{1'b0, 1'b0, 5'd0}; e1 = '{1'b0, 1'b0, 5'd0}; end
        endcase
        return sym ? e1 : e0;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mtm_tape_ram.sv
`default_nettype none

module mtm_tape_ram (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [mtm_pkg::TAPE_AW-1:0] i_waddr,
    input  wire logic                        i_wbit,
    input  wire logic                        i_re,
    input  wire logic [mtm_pkg::TAPE_AW-1:0] i_raddr,
    output logic                             o_rbit
);

    logic r_mem [mtm_pkg::TAPE_BITS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wbit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rbit <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/mtm_exec.sv
`default_nettype none

module mtm_exec (
    input  wire mtm_pkg::t_ex_req i_req,
    output mtm_pkg::t_ex_res      o_res
);

    localparam logic [mtm_pkg::TAPE_AW-1:0] LAST = mtm_pkg::TAPE_AW'(mtm_pkg::TAPE_BITS - 1);
    localparam logic [mtm_pkg::TAPE_AW-1:0] ONE  = mtm_pkg::TAPE_AW'(1);

    mtm_pkg::t_entry ent;

    always_comb begin
        ent = mtm_pkg::step_entry(i_req.state, i_req.sym);

        o_res           = '0;
        o_res.state     = i_req.state;
        o_res.head      = i_req.head;
        o_res.wr_addr   = i_req.head;

        case (i_req.req_type)
            mtm_pkg::REQ_LOAD: begin
                o_res.wr_en   = 32'(i_req.load_addr) < 32'(mtm_pkg::TAPE_BITS);
                o_res.wr_addr = mtm_pkg::TAPE_AW'(i_req.load_addr);
                o_res.wr_bit  = i_req.load_bit;
            end
            mtm_pkg::REQ_RESTART: begin
                o_res.state = '0;
                o_res.head  = '0;
            end
            mtm_pkg::REQ_STEP: begin
                if (i_req.state < mtm_pkg::NUM_STATES) begin
                    o_res.wr_en  = 1'b1;
                    o_res.wr_bit = ent.wr_one;
                    // The input state copies the stream bit over a blank cell.
                    if (i_req.state == mtm_pkg::ST_READ && !i_req.sym) begin
                        o_res.wr_bit   = i_req.in_bit;
                        o_res.in_taken = 1'b1;
                    end else if (i_req.state == mtm_pkg::ST_EMIT) begin
                        o_res.out_valid = 1'b1;
                        o_res.out_bit   = i_req.sym;
                    end
                    if (ent.mv_right) begin
                        if (i_req.head == LAST) begin
                            o_res.overflow = 1'b1;
                        end else begin
                            o_res.head = i_req.head + ONE;
                        end
                    end else if (i_req.head != '0) begin
                        o_res.head = i_req.head - ONE;
                    end
                    o_res.state = ent.nxt;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/monotone_turing_machine_step.sv
`default_nettype none

// Channel   Direction  Handshake           Word
// request   in         i_valid / o_ready   i_req_type, i_load_addr, i_load_bit, i_in_bit
// result    out        o_valid / i_ready   o_out_valid, o_out_bit, o_in_taken,
//                                          o_next_state, o_head_pos, o_head_overflow
//
// A step, restart or unused-code word is not overlapped by the next: the tape bit under the head
// comes back from the synchronous tape memory in the cycle after issue, and the next read waits
// for the head and state that the word leaves. Load words are taken one per cycle unless the
// output register stalls. After reset a clearing pass zeroes all TAPE_BITS (4096) cells, one cell
// a cycle; o_ready stays low during it. A result waits in the output register while a new word is
// taken; o_ready is also low while the word in execute waits on a full output register not taken.

module monotone_turing_machine_step (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [11:0] i_load_addr,
    input  wire logic        i_load_bit,
    input  wire logic        i_in_bit,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_out_valid,
    output logic             o_out_bit,
    output logic             o_in_taken,
    output logic [4:0]       o_next_state,
    output logic [11:0]      o_head_pos,
    output logic             o_head_overflow
);

    localparam logic [mtm_pkg::TAPE_AW-1:0] LAST = mtm_pkg::TAPE_AW'(mtm_pkg::TAPE_BITS - 1);

    logic                        r_clr_busy;
    logic [mtm_pkg::TAPE_AW-1:0] r_clr_addr;
    logic [mtm_pkg::TAPE_AW-1:0] r_head;
    logic [4:0]                  r_state;

    logic                        r_ex_valid;
    logic [1:0]                  r_ex_type;
    logic [11:0]                 r_ex_addr;
    logic                        r_ex_lbit;
    logic                        r_ex_ibit;
    logic                        r_ex_fwd_hit;
    logic                        r_ex_fwd_bit;

    logic                        r_o_valid;
    logic                        r_o_out_valid;
    logic                        r_o_out_bit;
    logic                        r_o_in_taken;
    logic [4:0]                  r_o_state;
    logic [mtm_pkg::TAPE_AW-1:0] r_o_head;
    logic                        r_o_overflow;

    logic                        n_o_valid;
    logic                        ex_fire;
    logic                        in_fire;
    logic                        ram_we;
    logic [mtm_pkg::TAPE_AW-1:0] ram_waddr;
    logic                        ram_wbit;
    logic                        ram_rbit;
    mtm_pkg::t_ex_req            ex_req;
    mtm_pkg::t_ex_res            ex_res;

    assign ex_fire = r_ex_valid && (!r_o_valid || i_ready);
    // A load never moves the head or changes the state, so only a load may overlap the next
    // issue.
    assign o_ready = !r_clr_busy
                   && (!r_ex_valid || (ex_fire && r_ex_type == mtm_pkg::REQ_LOAD));
    assign in_fire = i_valid && o_ready;

    assign ram_we    = r_clr_busy || (ex_fire && ex_res.wr_en);
    assign ram_waddr = r_clr_busy ? r_clr_addr : ex_res.wr_addr;
    assign ram_wbit  = r_clr_busy ? 1'b0 : ex_res.wr_bit;

    mtm_tape_ram u_tape (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wbit  (ram_wbit),
        .i_re    (in_fire),
        .i_raddr (r_head),
        .o_rbit  (ram_rbit)
    );

    always_comb begin
        ex_req.req_type  = r_ex_type;
        ex_req.load_addr = r_ex_addr;
        ex_req.load_bit  = r_ex_lbit;
        ex_req.in_bit    = r_ex_ibit;
        ex_req.sym       = r_ex_fwd_hit ? r_ex_fwd_bit : ram_rbit;
        ex_req.state     = r_state;
        ex_req.head      = r_head;
    end

    mtm_exec u_exec (
        .i_req (ex_req),
        .o_res (ex_res)
    );

    always_comb begin
        n_o_valid = r_o_valid;
        if (ex_fire) begin
            n_o_valid = 1'b1;
        end else if (i_ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_head     <= '0;
            r_state    <= '0;
            r_ex_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + mtm_pkg::TAPE_AW'(1);
                if (r_clr_addr == LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (ex_fire) begin
                r_head  <= ex_res.head;
                r_state <= ex_res.state;
            end
            if (in_fire) begin
                r_ex_valid <= 1'b1;
            end else if (ex_fire) begin
                r_ex_valid <= 1'b0;
            end
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ex_type    <= i_req_type;
            r_ex_addr    <= i_load_addr;
            r_ex_lbit    <= i_load_bit;
            r_ex_ibit    <= i_in_bit;
            // A load written in this cycle at the head is not yet seen by the read.
            r_ex_fwd_hit <= ram_we && ram_waddr == r_head;
            r_ex_fwd_bit <= ram_wbit;
        end
        if (ex_fire) begin
            r_o_out_valid <= ex_res.out_valid;
            r_o_out_bit   <= ex_res.out_bit;
            r_o_in_taken  <= ex_res.in_taken;
            r_o_state     <= ex_res.state;
            r_o_head      <= ex_res.head;
            r_o_overflow  <= ex_res.overflow;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_out_valid     = r_o_out_valid;
    assign o_out_bit       = r_o_out_bit;
    assign o_in_taken      = r_o_in_taken;
    assign o_next_state    = r_o_state;
    assign o_head_pos      = 12'(r_o_head);
    assign o_head_overflow = r_o_overflow;

endmodule

`default_nettype wire

// File: hw/rtl/mtm_checker.sv
`default_nettype none

module mtm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic [1:0]  i_req_type,
    input wire logic [11:0] i_load_addr,
    input wire logic        i_load_bit,
    input wire logic        i_in_bit,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic        o_out_valid,
    input wire logic        o_out_bit,
    input wire logic        o_in_taken,
    input wire logic [4:0]  o_next_state,
    input wire logic [11:0] o_head_pos,
    input wire logic        o_head_overflow
);

    localparam logic [11:0] LAST_POS = 12'(mtm_pkg::TAPE_BITS - 1);

    // A result word that is not taken must hold.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_next_state) && $stable(o_head_pos)
            && $stable(o_out_valid) && $stable(o_in_taken))
        else $error("result word changed while stalled");

    // The tape is being cleared right after reset, so no word may be taken.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("request taken during the clearing pass");

    a_overflow_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_head_overflow |-> o_head_pos == LAST_POS)
        else $error("overflow reported away from the last cell");

    // Reading the input stream and emitting a bit come from different states.
    a_io_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_in_taken |-> !o_out_valid && o_next_state == 5'd0)
        else $error("input and output reported by one step");

endmodule

bind monotone_turing_machine_step mtm_checker u_mtm_checker (.*);

`default_nettype wire
